// ===== sv/bsmm_pkg.sv =====
package bsmm_pkg;

   localparam int CAPACITY = 1024;
   localparam int ADDR_W   = $clog2(CAPACITY);
   localparam int COUNT_W  = 11;
   localparam int VALUE_W  = 32;
   localparam int GAP_W    = VALUE_W + 1;

   localparam logic [COUNT_W-1:0] CAPACITY_COUNT = COUNT_W'(CAPACITY);
   localparam logic [COUNT_W-1:0] LIMIT_RESET    = COUNT_W'(1024);
   localparam logic [GAP_W-1:0]   GAP_ONES       = '1;

   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic [COUNT_W-1:0]        repeat_count;
   } req_type;

   typedef struct packed {
      logic [COUNT_W-1:0] stored_count;
      logic [GAP_W-1:0]   shortest_gap;
      logic [GAP_W-1:0]   longest_span;
      logic               spans_valid;
      logic               full_refused;
   } rsp_type;

   typedef enum logic [4:0] {
      ST_IDLE  = 5'b00001,
      ST_CHECK = 5'b00010,
      ST_SCAN  = 5'b00100,
      ST_WRITE = 5'b01000,
      ST_SPAN  = 5'b10000
   } state_type;

endpackage

// ===== sv/bsmm_ram.sv =====
module bsmm_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/bsmm_gap_unit.sv =====
module bsmm_gap_unit (
   input  logic [bsmm_pkg::VALUE_W-1:0] a_bits,
   input  logic [bsmm_pkg::VALUE_W-1:0] b_bits,
   input  logic [bsmm_pkg::GAP_W-1:0]   bound,
   output logic [bsmm_pkg::GAP_W-1:0]   diff,
   output logic                         less
);
   import bsmm_pkg::*;

   logic [VALUE_W-1:0] key_a;
   logic [VALUE_W-1:0] key_b;
   logic [VALUE_W-1:0] mag;

   // Flipping the sign bit gives unsigned keys in the same order as the signed values.
   always_comb begin
      key_a = a_bits ^ {1'b1, {(VALUE_W-1){1'b0}}};
      key_b = b_bits ^ {1'b1, {(VALUE_W-1){1'b0}}};
      mag   = (key_a >= key_b) ? (key_a - key_b) : (key_b - key_a);
      diff  = {1'b0, mag};
      less  = (diff < bound);
   end

endmodule

// ===== sv/bounded_set_min_max_gap.sv =====
// Collects signed 32-bit values up to a limit set through the csr port and, for every
// transfer taken on the request side, returns one result transfer with the count held,
// the smallest gap between held values and the span from least to greatest. A request
// is taken while busy is low; the result appears as a one-cycle rsp_valid strobe and
// must be captured then. A request passes through ST_CHECK, then through ST_SCAN when
// the new value must be compared against every held value, read one per cycle through
// the single read port of the value memory, then through ST_WRITE when a copy is stored
// (ST_SCAN is skipped for an empty set or a gap already zero), and ends in ST_SPAN,
// which issues the result. busy falls as rsp_valid rises, so the next request can be
// taken at the edge that takes the result.
// Copies that do not fit are dropped and flagged with full_refused.
module bounded_set_min_max_gap (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             start,
   output logic                             busy,
   input  bsmm_pkg::req_type                req_data,
   output logic                             rsp_valid,
   output bsmm_pkg::rsp_type                rsp_data,
   input  logic                             csr_we,
   input  logic [bsmm_pkg::COUNT_W-1:0]     csr_wdata
);
   import bsmm_pkg::*;

   state_type          state_ff, state_in;
   logic [COUNT_W-1:0] limit_ff, limit_in;
   logic [COUNT_W-1:0] held_count_ff, held_count_in;
   logic [VALUE_W-1:0] least_ff, least_in;
   logic [VALUE_W-1:0] greatest_ff, greatest_in;
   logic [GAP_W-1:0]   gap_ff, gap_in;
   logic [VALUE_W-1:0] value_ff, value_in;
   logic [COUNT_W-1:0] add_n_ff, add_n_in;
   logic               refused_ff, refused_in;
   logic [COUNT_W-1:0] scan_idx_ff, scan_idx_in;
   logic               pend_ff, pend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   rsp_type            rsp_ff, rsp_in;

   logic [COUNT_W-1:0] limit_eff;
   logic [COUNT_W-1:0] room;
   logic               issue;
   logic               wr_en;
   logic [VALUE_W-1:0] rd_data;
   logic [VALUE_W-1:0] unit_a;
   logic [VALUE_W-1:0] unit_b;
   logic [GAP_W-1:0]   unit_diff;
   logic               unit_less;
   logic               spans_ok;

   bsmm_ram #(
      .WIDTH (VALUE_W),
      .DEPTH (CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (held_count_ff[ADDR_W-1:0]),
      .wr_data (value_ff),
      .rd_en   (issue),
      .rd_addr (scan_idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   bsmm_gap_unit u_gap (
      .a_bits (unit_a),
      .b_bits (unit_b),
      .bound  (gap_ff),
      .diff   (unit_diff),
      .less   (unit_less)
   );

   assign unit_a    = (state_ff == ST_SPAN) ? greatest_ff : rd_data;
   assign unit_b    = (state_ff == ST_SPAN) ? least_ff : value_ff;
   assign limit_eff = (limit_ff > CAPACITY_COUNT) ? CAPACITY_COUNT : limit_ff;
   assign room      = limit_eff - held_count_ff;
   assign issue     = (state_ff == ST_SCAN) && (scan_idx_ff < held_count_ff);
   assign wr_en     = (state_ff == ST_WRITE);
   assign spans_ok  = (held_count_ff >= COUNT_W'(2));
   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      state_in      = state_ff;
      limit_in      = csr_we ? csr_wdata : limit_ff;
      held_count_in = held_count_ff;
      least_in      = least_ff;
      greatest_in   = greatest_ff;
      gap_in        = gap_ff;
      value_in      = value_ff;
      add_n_in      = add_n_ff;
      refused_in    = refused_ff;
      scan_idx_in   = scan_idx_ff;
      pend_in       = issue;
      rsp_valid_in  = 1'b0;
      rsp_in        = rsp_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               value_in = req_data.value;
               if (held_count_ff >= limit_eff) begin
                  add_n_in   = '0;
                  refused_in = (req_data.repeat_count != '0);
               end else if (req_data.repeat_count > room) begin
                  add_n_in   = room;
                  refused_in = 1'b1;
               end else begin
                  add_n_in   = req_data.repeat_count;
                  refused_in = 1'b0;
               end
               state_in = ST_CHECK;
            end
         end
         ST_CHECK: begin
            scan_idx_in = '0;
            if (add_n_ff == '0) begin
               state_in = ST_SPAN;
            end else if ((held_count_ff != '0) && (gap_ff != '0)) begin
               state_in = ST_SCAN;
            end else begin
               state_in = ST_WRITE;
            end
         end
         ST_SCAN: begin
            if (issue) begin
               scan_idx_in = scan_idx_ff + COUNT_W'(1);
            end
            if (pend_ff && unit_less) begin
               gap_in = unit_diff;
            end
            if (!issue && !pend_ff) begin
               state_in = ST_WRITE;
            end
         end
         ST_WRITE: begin
            // A second copy of the same value makes the gap zero, and no scan follows
            // after that, so only the first copy needs to reach the memory.
            if (held_count_ff == '0) begin
               least_in    = value_ff;
               greatest_in = value_ff;
            end else begin
               if ((value_ff ^ {1'b1, {(VALUE_W-1){1'b0}}}) <
                   (least_ff ^ {1'b1, {(VALUE_W-1){1'b0}}})) begin
                  least_in = value_ff;
               end
               if ((value_ff ^ {1'b1, {(VALUE_W-1){1'b0}}}) >
                   (greatest_ff ^ {1'b1, {(VALUE_W-1){1'b0}}})) begin
                  greatest_in = value_ff;
               end
            end
            if (add_n_ff >= COUNT_W'(2)) begin
               gap_in = '0;
            end
            held_count_in = held_count_ff + add_n_ff;
            state_in      = ST_SPAN;
         end
         ST_SPAN: begin
            rsp_valid_in        = 1'b1;
            rsp_in.stored_count = held_count_ff;
            rsp_in.shortest_gap = spans_ok ? gap_ff : '0;
            rsp_in.longest_span = spans_ok ? unit_diff : '0;
            rsp_in.spans_valid  = spans_ok;
            rsp_in.full_refused = refused_ff;
            state_in            = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         limit_ff      <= LIMIT_RESET;
         held_count_ff <= '0;
         least_ff      <= '0;
         greatest_ff   <= '0;
         gap_ff        <= GAP_ONES;
         scan_idx_ff   <= '0;
         pend_ff       <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         limit_ff      <= limit_in;
         held_count_ff <= held_count_in;
         least_ff      <= least_in;
         greatest_ff   <= greatest_in;
         gap_ff        <= gap_in;
         scan_idx_ff   <= scan_idx_in;
         pend_ff       <= pend_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff   <= value_in;
      add_n_ff   <= add_n_in;
      refused_ff <= refused_in;
      rsp_ff     <= rsp_in;
   end

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == ST_SPAN))
      else $error("Result strobe without a finished request.");

   assert property (@(posedge clock) disable iff (reset)
      held_count_ff <= CAPACITY_COUNT)
      else $error("Held count exceeds the store depth.");

   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (state_ff == ST_CHECK))
      else $error("Accepted request did not start processing.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> (scan_idx_ff <= held_count_ff))
      else $error("Scan index ran past the held values.");

   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WRITE) |=> (held_count_ff <= limit_eff))
      else $error("Store grew beyond the configured limit.");

endmodule

// ===== tb/sv/bounded_set_min_max_gap_tb.sv =====
`timescale 1ns / 100ps

module bounded_set_min_max_gap_tb;
   import bsmm_pkg::*;

   localparam int TIMEOUT_CYCLES = 10_000_000;
   localparam logic signed [VALUE_W-1:0] INT_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [VALUE_W-1:0] INT_MIN = 32'sh8000_0000;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               start = 1'b0;
   logic               busy;
   req_type            req_data = '0;
   logic               rsp_valid;
   rsp_type            rsp_data;
   logic               csr_we = 1'b0;
   logic [COUNT_W-1:0] csr_wdata = '0;

   // Shadow copy of the set and the running measurements.
   logic signed [VALUE_W-1:0] held_values [CAPACITY];
   int                        held_total = 0;
   logic signed [VALUE_W-1:0] least_held = '0;
   logic signed [VALUE_W-1:0] greatest_held = '0;
   logic [GAP_W-1:0]          closest_gap = GAP_ONES;
   logic [COUNT_W-1:0]        capacity_limit = LIMIT_RESET;

   req_type                   pending_requests [$];
   rsp_type                   expected_status [$];
   bit                        seen_values [int];
   logic signed [VALUE_W-1:0] offered_values [$];
   logic signed [VALUE_W-1:0] cluster_base = '0;
   int                        sender_idle_pct = 28;

   int          error_count = 0;
   int          requests_queued = 0;
   int          requests_accepted = 0;
   int          results_checked = 0;
   int          refusals_seen = 0;
   int unsigned cycle_count = 0;
   rsp_type     want;
   rsp_type     got;

   bounded_set_min_max_gap dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   always @(posedge clock) cycle_count <= cycle_count + 1;

   function automatic logic [GAP_W-1:0] value_distance(logic signed [VALUE_W-1:0] a,
                                                        logic signed [VALUE_W-1:0] b);
      longint d;
      d = longint'(a) - longint'(b);
      if (d < 0) d = -d;
      return d[GAP_W-1:0];
   endfunction

   // Stores as many copies as the limit allows and reports the resulting status.
   function automatic rsp_type settle_request(req_type r);
      rsp_type                   s;
      int                        room;
      int                        k;
      int                        i;
      logic signed [VALUE_W-1:0] v;
      logic [GAP_W-1:0]          d;
      s = '0;
      v = $signed(r.value);
      room = (capacity_limit > CAPACITY_COUNT) ? CAPACITY : int'(capacity_limit);
      for (k = 0; k < int'(r.repeat_count); k++) begin
         if (held_total >= room) begin
            s.full_refused = 1'b1;
            break;
         end
         if (held_total == 0) begin
            least_held = v;
            greatest_held = v;
         end else begin
            if (closest_gap != '0) begin
               for (i = 0; i < held_total; i++) begin
                  d = value_distance(held_values[i], v);
                  if (d < closest_gap) closest_gap = d;
               end
            end
            if (v < least_held) least_held = v;
            if (v > greatest_held) greatest_held = v;
         end
         held_values[held_total] = v;
         held_total++;
      end
      s.stored_count = COUNT_W'(held_total);
      if (held_total >= 2) begin
         s.shortest_gap = closest_gap;
         s.longest_span = value_distance(greatest_held, least_held);
         s.spans_valid = 1'b1;
      end
      return s;
   endfunction

   function automatic logic signed [VALUE_W-1:0] unseen_value(bit near_cluster);
      logic signed [VALUE_W-1:0] v;
      do begin
         if (near_cluster) v = cluster_base + VALUE_W'($urandom_range(0, 2047));
         else v = $urandom;
      end while (seen_values.exists(int'(v)));
      return v;
   endfunction

   task automatic queue_request(logic signed [VALUE_W-1:0] v, int n);
      req_type r;
      r.value = v;
      r.repeat_count = COUNT_W'(n);
      seen_values[int'(v)] = 1'b1;
      offered_values = {offered_values, v};
      pending_requests = {pending_requests, r};
      requests_queued++;
   endtask

   task automatic flag_error(string msg);
      error_count++;
      if (error_count <= 10) $display("%0t: %s", $time, msg);
   endtask

   task automatic wait_idle();
      while (requests_accepted != requests_queued || expected_status.size() != 0 || busy)
         @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   task automatic set_capacity_limit(logic [COUNT_W-1:0] v);
      wait_idle();
      csr_we <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_we <= 1'b0;
      capacity_limit = v;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            expected_status = {expected_status, settle_request(req_data)};
            requests_accepted++;
         end
         if (start && busy) begin
            start <= 1'b1;
         end else if (pending_requests.size() != 0 &&
                      $urandom_range(0, 99) >= sender_idle_pct) begin
            start <= 1'b1;
            req_data <= pending_requests.pop_front();
         end else begin
            start <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         got = rsp_data;
         if (expected_status.size() == 0) begin
            flag_error($sformatf("result with no request outstanding: count=%0d gap=%0h",
                                 got.stored_count, got.shortest_gap));
         end else begin
            want = expected_status.pop_front();
            results_checked++;
            if (want.full_refused) refusals_seen++;
            if (got.stored_count !== want.stored_count ||
                got.shortest_gap !== want.shortest_gap ||
                got.longest_span !== want.longest_span ||
                got.spans_valid !== want.spans_valid ||
                got.full_refused !== want.full_refused) begin
               flag_error($sformatf({"result %0d: expected count=%0d gap=%0h span=%0h ",
                                     "valid=%0b refused=%0b, got count=%0d gap=%0h ",
                                     "span=%0h valid=%0b refused=%0b"},
                                    results_checked, want.stored_count, want.shortest_gap,
                                    want.longest_span, want.spans_valid, want.full_refused,
                                    got.stored_count, got.shortest_gap, got.longest_span,
                                    got.spans_valid, got.full_refused));
            end
         end
      end
   end

   initial begin
      wait (cycle_count >= TIMEOUT_CYCLES);
      $display("Timed out after %0d cycles with %0d results outstanding",
               cycle_count, expected_status.size());
      $display("DONE: errors detected");
      $finish;
   end

   initial begin
      int pick;
      int i;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // A zero limit stores nothing and refuses every nonzero run, including the largest.
      set_capacity_limit(COUNT_W'(0));
      queue_request(INT_MIN, 1);
      queue_request(0, 0);
      queue_request(INT_MAX, 1024);
      set_capacity_limit(COUNT_W'(1));
      queue_request(INT_MAX, 1);
      queue_request(INT_MAX, 0);
      queue_request(INT_MIN, 2);
      // A limit above the memory size saturates.
      set_capacity_limit(COUNT_W'(2047));
      queue_request(INT_MIN, 1);
      queue_request(0, 1);
      queue_request(1_000_000, 1);
      queue_request(0, 0);
      set_capacity_limit(COUNT_W'(2));
      queue_request(-1, 5);
      queue_request(-1, 0);
      wait_idle();
      set_capacity_limit(COUNT_W'(held_total + 1));
      queue_request(-7_000_000, 3);
      queue_request(123, 1);

      set_capacity_limit(COUNT_W'(1024));
      for (i = 0; i < 220; i++) begin
         pick = $urandom_range(0, 99);
         if (pick < 90) queue_request(unseen_value(1'b0), 1);
         else queue_request($urandom, 0);
      end

      wait_idle();
      sender_idle_pct = 86;
      cluster_base = $urandom;
      set_capacity_limit(COUNT_W'(held_total + 40));
      for (i = 0; i < 100; i++) begin
         pick = $urandom_range(0, 99);
         queue_request(unseen_value(pick < 40), 1);
      end
      wait_idle();
      set_capacity_limit(COUNT_W'(held_total - 10));
      for (i = 0; i < 20; i++) queue_request($urandom, $urandom_range(0, 1024));

      wait_idle();
      sender_idle_pct = 0;
      set_capacity_limit(COUNT_W'(2047));
      for (i = 0; i < 225; i++) begin
         pick = $urandom_range(0, 99);
         if (i == 180) queue_request($urandom, 1024);
         else if (i == 181) queue_request($urandom, 1023);
         else if (i > 181) queue_request($urandom, $urandom_range(0, 1024));
         else if (pick < 45) queue_request(unseen_value(1'b0), 1);
         else if (pick < 65)
            queue_request(offered_values[$urandom_range(0, offered_values.size() - 1)], 1);
         else if (pick < 80) queue_request($urandom, $urandom_range(2, 20));
         else if (pick < 90) queue_request($urandom, 0);
         else queue_request($urandom, $urandom_range(21, 200));
      end

      wait_idle();
      repeat (20) @(posedge clock);
      $display("Checked %0d results for %0d requests over limits from 0 to 2047 and three",
               results_checked, requests_accepted);
      $display("sender pacing profiles; %0d results flagged refusals, final set size %0d.",
               refusals_seen, held_total);
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
sv/bsmm_pkg.sv
sv/bsmm_ram.sv
sv/bsmm_gap_unit.sv
sv/bounded_set_min_max_gap.sv
tb/sv/bounded_set_min_max_gap_tb.sv
